// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file lkvc_checker.sv.
// Depends on nothing; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define LKVC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LKVC_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/lkvc_pkg.sv -----
// Types and constants of the LRU key-value cache.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lkvc_pkg;

  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_BITS-1:0]   lookup_key;
    logic [VALUE_BITS-1:0] store_value;
  } lkvc_in_t;

  typedef struct packed {
    logic                  hit;
    logic [VALUE_BITS-1:0] read_value;
  } lkvc_out_t;

endpackage

// ----- sv/lkvc_store.sv -----
// Fully associative entry store with age ranks: parallel key match,
// hit read, eviction and insertion in one pass. Depends on lkvc_pkg.
`timescale 1ns / 1ps

module lkvc_store #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  lkvc_pkg::lkvc_in_t         cmd,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg,
  output lkvc_pkg::lkvc_out_t        res
);
  import lkvc_pkg::*;

  localparam int RW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW    = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (CW > CFG_W) ? CW : CFG_W;

  logic [KEY_BITS-1:0]   key_r   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] value_r [MAX_ENTRIES];
  logic [RW-1:0]         rank_r  [MAX_ENTRIES];
  logic [RW-1:0]         rank_nxt[MAX_ENTRIES];
  logic [RW-1:0]         rank1   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]         count_r, count_nxt;

  logic [MAX_ENTRIES-1:0] match, valid1, victim, valid2, free_v, free_oh;
  logic                  hit;
  logic [RW-1:0]         hit_rank;
  logic [VALUE_BITS-1:0] hit_val;
  logic [CW-1:0]         cnt1, cnt2;
  logic [CAP_W-1:0]      cfg_ext, cap;
  logic                  do_evict;

  always_comb begin
    cfg_ext = CAP_W'(cfg);
    if (cfg_ext == '0) begin
      cap = CAP_W'(1);
    end else if (cfg_ext > CAP_W'(MAX_ENTRIES)) begin
      cap = CAP_W'(MAX_ENTRIES);
    end else begin
      cap = cfg_ext;
    end
  end

  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == cmd.lookup_key);
      hit_rank = hit_rank | (match[i] ? rank_r[i] : '0);
      hit_val  = hit_val | (match[i] ? value_r[i] : '0);
    end
    hit = |match;
  end

  always_comb begin
    cnt1     = count_r - CW'(hit);
    do_evict = (CAP_W'(cnt1) >= cap) && (cnt1 != '0);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank1[i]  = rank_r[i] - RW'(hit && (rank_r[i] > hit_rank));
      valid1[i] = valid_r[i] && !match[i];
      victim[i] = valid1[i] && do_evict && (CW'(rank1[i]) == cnt1 - CW'(1));
    end
    valid2  = valid1 & ~victim;
    cnt2    = cnt1 - CW'(|victim);
    free_v  = ~valid2;
    free_oh = free_v & (~free_v + MAX_ENTRIES'(1));
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (go && cmd.opcode == OP_SET) begin
      valid_nxt = valid2 | free_oh;
      count_nxt = cnt2 + CW'(|free_oh);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (free_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid2[i]) begin
          rank_nxt[i] = rank1[i] + RW'(1);
        end
      end
    end else if (go && hit) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (match[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && rank_r[i] < hit_rank) begin
          rank_nxt[i] = rank_r[i] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && cmd.opcode == OP_SET) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (free_oh[i]) begin
          key_r[i]   <= cmd.lookup_key;
          value_r[i] <= cmd.store_value;
        end
      end
    end
  end

  assign res.hit        = hit;
  assign res.read_value = hit_val;

endmodule

// ----- sv/lru_key_value_cache.sv -----
// LRU key-value cache top level: input register, entry store, result register.
// A get's result goes from the input register through the store into the result register.
// Throughput: one item per cycle; a get waits only while a held result is not taken.
// A set gives no result. Capacity register written on any cfg transfer.
// Reset (synchronous, active low) empties the store and sets capacity to 16.
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lkvc_pkg::lkvc_in_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lkvc_pkg::lkvc_out_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_data
);
  import lkvc_pkg::*;

  lkvc_in_t         req_r;
  logic             req_vld_r;
  lkvc_out_t        out_r;
  logic             out_vld_r;
  logic [CFG_W-1:0] cfg_r;
  lkvc_out_t        res;
  logic             go;

  assign go        = req_vld_r && (req_r.opcode == OP_SET || !out_vld_r || out_ready);
  assign in_ready  = !req_vld_r || go;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  lkvc_store #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .cmd  (req_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      cfg_r     <= CFG_RESET;
    end else begin
      if (in_ready) begin
        req_vld_r <= in_valid;
      end
      if (go && req_r.opcode == OP_GET) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    if (go && req_r.opcode == OP_GET) begin
      out_r <= res;
    end
  end

endmodule

// ----- sv/lkvc_checker.sv -----
// Port-level checks of the LRU key-value cache, bound to the top level.
// Depends on lkvc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lkvc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input lkvc_pkg::lkvc_in_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input lkvc_pkg::lkvc_out_t        out_data,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [lkvc_pkg::CFG_W-1:0] cfg_data
);
  import lkvc_pkg::*;

  logic out_stall;
  logic miss_value;

  assign out_stall  = out_valid && !out_ready;
  assign miss_value = out_valid && !out_data.hit && (|out_data.read_value);

  `LKVC_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid, "result valid after reset")
  `LKVC_ASSERT(a_miss_zero, clk, rst_n, !miss_value, "miss carries nonzero value")
  `LKVC_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_stall, "input stalled")
  `LKVC_ASSERT(a_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_data), "result moved")

endmodule

bind lru_key_value_cache lkvc_checker u_checker (.*);

// ----- bench/lru_key_value_cache_tb.sv -----
// Self-checking bench for lru_key_value_cache: directed rows, then random get/set traffic
// under several capacities, with random stalls on both sides and one long result hold-off.
// Depends on lkvc_pkg and the lru_key_value_cache RTL.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int PRESSURE_ITEMS = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    lkvc_in_t  item;
    bit        typed;
    lkvc_out_t want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  lkvc_in_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  lkvc_out_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [KEY_BITS-1:0]   slot_key [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] slot_val [MAX_ENTRIES];
  bit                    slot_used [MAX_ENTRIES];
  int unsigned           slot_rank [MAX_ENTRIES];
  int unsigned           used_count = 0;
  logic [CFG_W-1:0]      capacity_reg = CFG_RESET;

  lkvc_out_t   lookup_results [$];
  row_t        directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          steady = 1'b0;
  bit          hold_off_req = 1'b0;

  logic [CFG_W-1:0] cap_plan [10] = '{5'd1, 5'd0, 5'd5, 5'd31, 5'd2,
                                     5'd12, 5'd17, 5'd16, 5'd8, 5'd3};

  lru_key_value_cache DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end
  end

  function automatic int unsigned eff_capacity();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return capacity_reg;
  endfunction

  function automatic void drop_slot(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
    slot_used[s] = 1'b0;
    slot_rank[s] = 0;
    if (used_count > 0) used_count--;
  endfunction

  // Update the cache image with one item; return 1 when the item yields a lookup result.
  function automatic bit cache_apply(input lkvc_in_t item, output lkvc_out_t res);
    int found;
    int oldest;
    int free_slot;
    int unsigned r;
    found = -1;
    oldest = -1;
    free_slot = -1;
    res = '0;
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (found < 0 && slot_used[i] && slot_key[i] == item.lookup_key) found = i;
    if (item.opcode == OP_GET) begin
      if (found >= 0) begin
        res.hit = 1'b1;
        res.read_value = slot_val[found];
        r = slot_rank[found];
        for (int i = 0; i < MAX_ENTRIES; i++)
          if (slot_used[i] && slot_rank[i] < r) slot_rank[i]++;
        slot_rank[found] = 0;
      end
      return 1'b1;
    end
    if (found >= 0) drop_slot(found);
    if (used_count >= eff_capacity()) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_used[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest])) oldest = i;
      if (oldest >= 0) drop_slot(oldest);
    end
    for (int i = 0; i < MAX_ENTRIES; i++)
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    if (free_slot >= 0) begin
      for (int i = 0; i < MAX_ENTRIES; i++)
        if (slot_used[i]) slot_rank[i]++;
      slot_key[free_slot] = item.lookup_key;
      slot_val[free_slot] = item.store_value;
      slot_used[free_slot] = 1'b1;
      slot_rank[free_slot] = 0;
      used_count++;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic void add_row(row_kind_t kind, logic op, logic [31:0] key,
                                  logic [31:0] val, bit typed, logic hit, logic [31:0] rv);
    row_t row;
    row.kind = kind;
    row.item.opcode = op;
    row.item.lookup_key = key;
    row.item.store_value = val;
    row.typed = typed;
    row.want.hit = hit;
    row.want.read_value = rv;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input lkvc_out_t want,
                                 input lkvc_out_t got);
    $display("mismatch at cycle %0d: %s: expected hit=%0b value=%h, got hit=%0b value=%h",
             cycle_count, what, want.hit, want.read_value, got.hit, got.read_value);
    mismatch_count++;
  endtask

  // Offer one item after a random gap; predict on the transfer.
  task automatic send_item(input lkvc_in_t item, input bit typed, input lkvc_out_t want);
    int gap;
    lkvc_out_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cache_apply(item, predicted)) lookup_results.push_back(typed ? want : predicted);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lookup_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    capacity_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    lkvc_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lookup_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_data);
      end else begin
        want = lookup_results.pop_front();
        if (out_data.hit !== want.hit) report_mismatch("hit flag", want, out_data);
        if (out_data.read_value !== want.read_value)
          report_mismatch("read value", want, out_data);
      end
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    lkvc_in_t    item;
    row_t        row;
    logic [31:0] key_pool [32];
    int          pool_size;

    add_row(ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF);
    add_row(ROW_ITEM, OP_SET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'hA5A5_A5A5);
    add_row(ROW_CFG, OP_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'h0000_0001, 32'h1111_1111, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'hFFFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_CFG, OP_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'h0000_0002, 32'h2222_2222, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0001, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0002, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_CFG, OP_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'h0000_0003, 32'h3333_3333, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_SET, 32'h8000_0004, 32'h5555_AAAA, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0002, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h0000_0003, 32'h0, 1'b0, 1'b0, 32'h0);
    add_row(ROW_ITEM, OP_GET, 32'h8000_0004, 32'h0, 1'b0, 1'b0, 32'h0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) write_capacity(row.item.store_value[CFG_W-1:0]);
      else send_item(row.item, row.typed, row.want);
    end

    // Hold results off for a long stretch while gets keep coming.
    steady = 1'b1;
    hold_off_req = 1'b1;
    repeat (PRESSURE_ITEMS) begin
      item.opcode = OP_GET;
      item.lookup_key = $urandom_range(0, 4);
      item.store_value = $urandom;
      send_item(item, 1'b0, '0);
    end
    steady = 1'b0;

    foreach (cap_plan[p]) begin
      write_capacity(cap_plan[p]);
      steady = (p % 4 == 3);
      pool_size = $urandom_range(eff_capacity(), eff_capacity() + 6);
      for (int k = 0; k < pool_size; k++)
        key_pool[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
      repeat (ITEMS_PER_PHASE) begin
        item.opcode = ($urandom_range(0, 99) < 55) ? OP_GET : OP_SET;
        item.lookup_key = ($urandom_range(0, 9) == 0) ? $urandom
                                                      : key_pool[$urandom_range(0, pool_size - 1)];
        item.store_value = $urandom;
        send_item(item, 1'b0, '0);
      end
    end
    steady = 1'b0;

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
